// ===== hw/rtl/kfd_pkg.sv =====
// Shared types and constants for the KISS frame deframer.
// Used by every module under hw/rtl; depends on nothing.
package kfd_pkg;

	// KISS special bytes
	localparam logic [7:0] KISS_FEND  = 8'hC0;
	localparam logic [7:0] KISS_FESC  = 8'hDB;
	localparam logic [7:0] KISS_TFEND = 8'hDC;
	localparam logic [7:0] KISS_TFESC = 8'hDD;

	// Largest number of payload bytes kept in one frame.
	localparam int FRAME_CAPACITY = 512;

	// The count register must hold the capacity itself and feed a 10-bit port.
	localparam int CAP_BITS  = $clog2(FRAME_CAPACITY + 1);
	localparam int CNT_W     = (CAP_BITS > 10) ? CAP_BITS : 10;
	localparam int OUT_CNT_W = 10;

	// Depth of the queue between the front and the back.
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Byte classes decided by the front.
	localparam logic [2:0] CLS_OTHER = 3'd0;
	localparam logic [2:0] CLS_FEND  = 3'd1;
	localparam logic [2:0] CLS_FESC  = 3'd2;
	localparam logic [2:0] CLS_TFEND = 3'd3;
	localparam logic [2:0] CLS_TFESC = 3'd4;

	// Result kinds.
	localparam logic KIND_DATA = 1'b0;
	localparam logic KIND_END  = 1'b1;

	typedef struct packed {
		logic [2:0] cls;
		logic [7:0] data;
	} item_t;

	// Queue status as seen by its two users.
	typedef struct packed {
		logic  full;
		logic  empty;
	} queue_status_t;

endpackage

// ===== hw/rtl/kfd_front.sv =====
// Front end of the KISS frame deframer: accepts bytes and classifies them.
// Depends on kfd_pkg; feeds kfd_queue.
module kfd_front (
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [7:0]             in_byte,
	input  kfd_pkg::queue_status_t q_status,
	output logic                   push,
	output kfd_pkg::item_t         push_item
);

	logic [2:0] cls;

	always_comb begin
		case (in_byte)
			kfd_pkg::KISS_FEND:  cls = kfd_pkg::CLS_FEND;
			kfd_pkg::KISS_FESC:  cls = kfd_pkg::CLS_FESC;
			kfd_pkg::KISS_TFEND: cls = kfd_pkg::CLS_TFEND;
			kfd_pkg::KISS_TFESC: cls = kfd_pkg::CLS_TFESC;
			default:             cls = kfd_pkg::CLS_OTHER;
		endcase
	end

	assign in_stall       = q_status.full;
	assign push           = in_valid && !q_status.full;
	assign push_item.cls  = cls;
	assign push_item.data = in_byte;

endmodule

// ===== hw/rtl/kfd_queue.sv =====
// Short queue of classified bytes between the front and the back.
// Depends on kfd_pkg.
module kfd_queue (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  kfd_pkg::item_t         push_item,
	input  logic                   pop,
	output kfd_pkg::item_t         head_item,
	output kfd_pkg::queue_status_t status
);

	kfd_pkg::item_t                  mem_q [kfd_pkg::QUEUE_DEPTH];
	logic [kfd_pkg::QPTR_W-1:0]      wr_ptr_q;
	logic [kfd_pkg::QPTR_W-1:0]      rd_ptr_q;
	logic [kfd_pkg::QCNT_W-1:0]      count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign head_item    = mem_q[rd_ptr_q];
	assign status.full  = (count_q == kfd_pkg::QCNT_W'(kfd_pkg::QUEUE_DEPTH));
	assign status.empty = (count_q == '0);

	a_no_overfill: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= kfd_pkg::QCNT_W'(kfd_pkg::QUEUE_DEPTH))
		else $error("queue count beyond its depth");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		status.full |-> !push)
		else $error("push into a full queue");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		status.empty |-> !pop)
		else $error("pop from an empty queue");

endmodule

// ===== hw/rtl/kfd_back.sv =====
// Back end of the KISS frame deframer: frame state machine and result register.
// Depends on kfd_pkg; drains kfd_queue.
module kfd_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  kfd_pkg::queue_status_t         q_status,
	input  kfd_pkg::item_t                 head_item,
	output logic                           pop,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic                           result_kind,
	output logic [7:0]                     command_byte,
	output logic [7:0]                     payload_byte,
	output logic [kfd_pkg::OUT_CNT_W-1:0]  byte_count
);

	localparam logic [1:0] PH_HUNT = 2'd0;
	localparam logic [1:0] PH_CMD  = 2'd1;
	localparam logic [1:0] PH_DATA = 2'd2;
	localparam logic [1:0] PH_ESC  = 2'd3;

	localparam logic [kfd_pkg::CNT_W-1:0] CAP = kfd_pkg::CNT_W'(kfd_pkg::FRAME_CAPACITY);

	logic [1:0]                  phase_q;
	logic [7:0]                  cmd_q;
	logic [kfd_pkg::CNT_W-1:0]   cnt_q;

	logic                        res_valid_q;
	logic                        kind_q;
	logic [7:0]                  res_cmd_q;
	logic [7:0]                  res_pay_q;
	logic [kfd_pkg::CNT_W-1:0]   res_cnt_q;

	logic                        advance;
	logic                        has_room;
	logic [1:0]                  phase_d;
	logic                        emit;
	logic                        emit_kind;
	logic [7:0]                  emit_pay;
	logic                        do_store;
	logic                        load_cmd;

	assign advance  = !res_valid_q || !out_stall;
	assign pop      = advance && !q_status.empty;
	assign has_room = (cnt_q < CAP);

	always_comb begin
		phase_d   = phase_q;
		emit      = 1'b0;
		emit_kind = kfd_pkg::KIND_DATA;
		emit_pay  = head_item.data;
		do_store  = 1'b0;
		load_cmd  = 1'b0;
		case (phase_q)
			PH_HUNT: begin
				if (head_item.cls == kfd_pkg::CLS_FEND) begin
					phase_d = PH_CMD;
				end
			end
			PH_CMD: begin
				if (head_item.cls != kfd_pkg::CLS_FEND) begin
					load_cmd = 1'b1;
					phase_d  = PH_DATA;
				end
			end
			PH_DATA: begin
				case (head_item.cls)
					kfd_pkg::CLS_FEND: begin
						emit      = 1'b1;
						emit_kind = kfd_pkg::KIND_END;
						emit_pay  = 8'h00;
						phase_d   = PH_CMD;
					end
					kfd_pkg::CLS_FESC: begin
						phase_d = PH_ESC;
					end
					default: begin
						do_store = has_room;
					end
				endcase
			end
			default: begin
				// A bad escape, FEND included, is swallowed and the frame goes on.
				if (head_item.cls == kfd_pkg::CLS_TFEND) begin
					do_store = has_room;
					emit_pay = kfd_pkg::KISS_FEND;
				end else if (head_item.cls == kfd_pkg::CLS_TFESC) begin
					do_store = has_room;
					emit_pay = kfd_pkg::KISS_FESC;
				end
				phase_d = PH_DATA;
			end
		endcase
		if (do_store) begin
			emit = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HUNT;
			cmd_q       <= '0;
			cnt_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				phase_q <= phase_d;
				if (load_cmd) begin
					cmd_q <= head_item.data;
					cnt_q <= '0;
				end else if (do_store) begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
			if (advance) begin
				res_valid_q <= pop && emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && emit) begin
			kind_q    <= emit_kind;
			res_cmd_q <= cmd_q;
			res_pay_q <= emit_pay;
			res_cnt_q <= cnt_q;
		end
	end

	assign out_valid    = res_valid_q;
	assign result_kind  = kind_q;
	assign command_byte = res_cmd_q;
	assign payload_byte = res_pay_q;
	assign byte_count   = res_cnt_q[kfd_pkg::OUT_CNT_W-1:0];

	a_cnt_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CAP)
		else $error("stored count beyond frame capacity");

	a_end_zero_payload: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && kind_q == kfd_pkg::KIND_END |-> res_pay_q == 8'h00)
		else $error("frame end carries a payload byte");

	a_no_pop_held: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && out_stall |-> !pop)
		else $error("queue drained while a result is held");

	a_store_counts: assert property (@(posedge clk) disable iff (!arst_n)
		pop && do_store |=> cnt_q == $past(cnt_q) + 1'b1)
		else $error("stored byte not counted");

endmodule

// ===== hw/rtl/kiss_frame_deframer_top.sv =====
// Top level of the KISS frame deframer.
// Depends on kfd_pkg, kfd_front, kfd_queue and kfd_back.

// The block takes one received byte per clock cycle while in_stall is low and
// strips KISS framing: it hunts for an opening FEND, takes the first non-FEND
// byte as the frame's command, unescapes FESC TFEND and FESC TFESC, and emits
// each stored payload byte at once with its index, then a frame-end result
// carrying the command and the stored length on the closing FEND. Bytes past
// the frame capacity are dropped uncounted. The front classifies bytes into a
// four-entry queue and the back runs the frame state machine into a result
// register, so a byte goes through both before its result reaches the output,
// and the sustained rate is one byte per cycle while the output side does not
// stall. in_stall rises only once the queue is full.
module kiss_frame_deframer_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [7:0]                    in_byte,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          result_kind,
	output logic [7:0]                    command_byte,
	output logic [7:0]                    payload_byte,
	output logic [kfd_pkg::OUT_CNT_W-1:0] byte_count
);

	kfd_pkg::queue_status_t q_status;
	kfd_pkg::item_t         push_item;
	kfd_pkg::item_t         head_item;
	logic                   push;
	logic                   pop;

	kfd_front u_front (
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_byte   (in_byte),
		.q_status  (q_status),
		.push      (push),
		.push_item (push_item)
	);

	kfd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head_item (head_item),
		.status    (q_status)
	);

	kfd_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_status     (q_status),
		.head_item    (head_item),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.result_kind  (result_kind),
		.command_byte (command_byte),
		.payload_byte (payload_byte),
		.byte_count   (byte_count)
	);

endmodule
